/* rtl/glb_pkg.sv */
package glb_pkg;

  localparam int unsigned CodeW    = 21;
  localparam int unsigned GlyphW   = 16;
  localparam int unsigned AdvW     = 16;
  localparam int unsigned BearW    = 16;
  localparam int unsigned XW       = 23;
  localparam int unsigned PenW     = 22;
  localparam int unsigned ColW     = 16;
  localparam int unsigned LineW    = 7;
  localparam int unsigned StepW    = 26;
  localparam int unsigned YW       = 26;
  localparam int unsigned RunW     = 7;
  localparam int unsigned FracBits = 10;
  localparam int unsigned ProdW    = LineW + StepW;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 26;

  localparam logic [CodeW-1:0]   NewlineCode   = CodeW'(10);
  localparam logic [ColW-1:0]    WrapColReset  = '1;
  localparam logic [CfgIdxW-1:0] CfgWrapColumn = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgLineStep   = CfgIdxW'(1);

  // One placed character as it travels along the sorting row.
  typedef struct packed {
    logic [GlyphW-1:0] glyph;
    logic [XW-1:0]     x;
    logic [LineW-1:0]  line;
  } entry_t;

  // Control shared by every cell of the row.
  typedef struct packed {
    logic   insert;
    logic   shift;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

/* rtl/glyph_layout_batcher_core.sv */
// Glyph layout batcher core.
//
// A text arrives as a series of character requests on start_i while busy_o
// is low; each request carries a code point, glyph index, advance and left
// bearing, and last_char_i marks the final character. Newlines are dropped
// and open a new line; every other character is placed at the current pen
// and inserted into a row of MAX_CHARS sorting cells, so one request can be
// taken every cycle while the text is loading. Requests past MAX_CHARS per
// text change nothing but still end the text when marked last.
// After the last request the row holds the entries sorted by glyph in
// descending order, ties in arrival order. busy_o is then high while the row
// shifts one entry per cycle into the output register, so the N results
// come out registered, one per cycle, result_valid_o high for one cycle each.
// A text with no visible character yields one empty marker in the cycle right
// after its last request. The receiver cannot stall results.
// Configuration writes go through cfg_we_i, cfg_idx_i and cfg_wdata_i and
// take effect at once; the user must make them only while the block is idle,
// as the block itself does not enforce it. Reset clears pen, column, line and
// counters and sets the wrap column to all ones.
module glyph_layout_batcher_core #(
  parameter int unsigned MAX_CHARS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [glb_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [glb_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [glb_pkg::CodeW-1:0]      char_code_i,
  input  logic [glb_pkg::GlyphW-1:0]     glyph_index_i,
  input  logic [glb_pkg::AdvW-1:0]       advance_i,
  input  logic signed [glb_pkg::BearW-1:0] left_bearing_i,
  input  logic                           last_char_i,
  output logic                           result_valid_o,
  output logic [glb_pkg::GlyphW-1:0]     out_glyph_o,
  output logic signed [glb_pkg::XW-1:0]  x_pos_o,
  output logic [glb_pkg::YW-1:0]         y_pos_o,
  output logic                           run_end_o,
  output logic [glb_pkg::RunW-1:0]       run_length_o,
  output logic                           last_out_o
);

  localparam int unsigned CntW = $clog2(MAX_CHARS + 1);

  // Configuration registers.
  logic [glb_pkg::ColW-1:0]  wrap_col_q;
  logic [glb_pkg::StepW-1:0] line_step_q;

  // Per-text layout state.
  logic [glb_pkg::PenW-1:0]  pen_q, pen_d;
  logic [glb_pkg::ColW-1:0]  col_q, col_d;
  logic [glb_pkg::LineW-1:0] line_q, line_d;
  logic [CntW-1:0]           stored_q, stored_d;
  logic [CntW-1:0]           taken_q, taken_d;

  // Drain control.
  logic                      busy_q, busy_d;
  logic [CntW-1:0]           remain_q, remain_d;
  logic [glb_pkg::RunW-1:0]  run_q, run_d;

  logic                      accept;
  logic                      take;
  logic                      newline_hit;
  logic [glb_pkg::XW-1:0]    x_new;
  glb_pkg::cell_ctrl_t       ctrl;
  glb_pkg::entry_t           head;
  glb_pkg::entry_t           second;
  logic                      second_valid;
  logic                      end_run;
  logic [glb_pkg::ProdW-1:0] y_prod;

  assign accept      = start_i && !busy_q;
  assign take        = accept && (taken_q < CntW'(MAX_CHARS));
  assign newline_hit = (char_code_i == glb_pkg::NewlineCode);

  // Pen minus the sign-extended bearing, modulo 2^23.
  assign x_new = {1'b0, pen_q} - {{(glb_pkg::XW - glb_pkg::BearW){left_bearing_i[15]}},
                                  left_bearing_i};

  assign ctrl.insert          = take && !newline_hit;
  assign ctrl.shift           = busy_q;
  assign ctrl.new_entry.glyph = glyph_index_i;
  assign ctrl.new_entry.x     = x_new;
  assign ctrl.new_entry.line  = line_q;

  glb_chain #(
    .Depth (MAX_CHARS)
  ) u_chain (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .head_o         (head),
    .second_o       (second),
    .second_valid_o (second_valid)
  );

  // Placement and text bookkeeping.
  always_comb begin
    pen_d    = pen_q;
    col_d    = col_q;
    line_d   = line_q;
    stored_d = stored_q;
    taken_d  = taken_q;
    if (take) begin
      taken_d = taken_q + CntW'(1);
      if (newline_hit) begin
        pen_d  = '0;
        col_d  = '0;
        line_d = line_q + glb_pkg::LineW'(1);
      end else begin
        stored_d = stored_q + CntW'(1);
        if (col_q == wrap_col_q) begin
          pen_d  = '0;
          col_d  = '0;
          line_d = line_q + glb_pkg::LineW'(1);
        end else begin
          pen_d = pen_q + glb_pkg::PenW'(advance_i);
          col_d = col_q + glb_pkg::ColW'(1);
        end
      end
    end
  end

  // The run ends at the last entry or where the following glyph differs.
  assign end_run = (remain_q == CntW'(1)) || !second_valid || (second.glyph != head.glyph);
  assign y_prod  = glb_pkg::ProdW'(head.line) * glb_pkg::ProdW'(line_step_q);

  always_comb begin
    busy_d   = busy_q;
    remain_d = remain_q;
    run_d    = run_q;
    if (busy_q) begin
      remain_d = remain_q - CntW'(1);
      run_d    = end_run ? '0 : run_q + glb_pkg::RunW'(1);
      if (remain_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end else if (accept && last_char_i && (stored_d != '0)) begin
      busy_d   = 1'b1;
      remain_d = stored_d;
      run_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_col_q     <= glb_pkg::WrapColReset;
      line_step_q    <= '0;
      pen_q          <= '0;
      col_q          <= '0;
      line_q         <= '0;
      stored_q       <= '0;
      taken_q        <= '0;
      busy_q         <= 1'b0;
      remain_q       <= '0;
      run_q          <= '0;
      result_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          glb_pkg::CfgWrapColumn: wrap_col_q  <= cfg_wdata_i[glb_pkg::ColW-1:0];
          glb_pkg::CfgLineStep:   line_step_q <= cfg_wdata_i[glb_pkg::StepW-1:0];
          default: ;
        endcase
      end
      busy_q   <= busy_d;
      remain_q <= remain_d;
      run_q    <= run_d;
      // The text state returns to zero as soon as the last request is taken.
      if (accept && last_char_i) begin
        pen_q    <= '0;
        col_q    <= '0;
        line_q   <= '0;
        stored_q <= '0;
        taken_q  <= '0;
      end else begin
        pen_q    <= pen_d;
        col_q    <= col_d;
        line_q   <= line_d;
        stored_q <= stored_d;
        taken_q  <= taken_d;
      end
      result_valid_o <= busy_q || (accept && last_char_i && (stored_d == '0));
    end
  end

  // Result payload: the head of the row while draining, else the empty marker.
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      out_glyph_o  <= head.glyph;
      x_pos_o      <= head.x;
      y_pos_o      <= glb_pkg::YW'(y_prod[glb_pkg::ProdW-1:glb_pkg::FracBits]);
      run_end_o    <= end_run;
      run_length_o <= end_run ? run_q + glb_pkg::RunW'(1) : '0;
      last_out_o   <= (remain_q == CntW'(1));
    end else begin
      out_glyph_o  <= '0;
      x_pos_o      <= '0;
      y_pos_o      <= '0;
      run_end_o    <= 1'b0;
      run_length_o <= '0;
      last_out_o   <= 1'b1;
    end
  end

  assign busy_o = busy_q;

endmodule

/* rtl/glb_cell.sv */
module glb_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  glb_pkg::cell_ctrl_t ctrl_i,
  input  glb_pkg::entry_t     prev_entry_i,
  input  logic                prev_valid_i,
  input  logic                prev_keep_i,
  input  glb_pkg::entry_t     next_entry_i,
  input  logic                next_valid_i,
  output glb_pkg::entry_t     entry_o,
  output logic                valid_o,
  output logic                keep_o
);

  glb_pkg::entry_t entry_q, entry_d;
  logic            valid_q, valid_d;

  // A cell keeps its entry on insertion when its glyph is not below the new
  // one; equal glyphs stay ahead, which makes the sort stable.
  assign keep_o = valid_q && (entry_q.glyph >= ctrl_i.new_entry.glyph);

  always_comb begin
    entry_d = entry_q;
    valid_d = valid_q;
    if (ctrl_i.shift) begin
      entry_d = next_entry_i;
      valid_d = next_valid_i;
    end else if (ctrl_i.insert && !keep_o) begin
      if (prev_keep_i) begin
        entry_d = ctrl_i.new_entry;
        valid_d = 1'b1;
      end else begin
        entry_d = prev_entry_i;
        valid_d = prev_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign valid_o = valid_q;

endmodule

/* rtl/glb_chain.sv */
module glb_chain #(
  parameter int unsigned Depth = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  glb_pkg::cell_ctrl_t ctrl_i,
  output glb_pkg::entry_t     head_o,
  output glb_pkg::entry_t     second_o,
  output logic                second_valid_o
);

  glb_pkg::entry_t ent [Depth+1];
  logic            vld [Depth+1];
  logic            keep[Depth];

  // Link Depth is the empty slot beyond the tail; link 0 feeds the head.
  assign ent[Depth] = '0;
  assign vld[Depth] = 1'b0;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    glb_pkg::entry_t p_ent;
    logic            p_vld;
    logic            p_keep;
    if (i == 0) begin : g_head
      assign p_ent  = ctrl_i.new_entry;
      assign p_vld  = 1'b0;
      assign p_keep = 1'b1;
    end else begin : g_body
      assign p_ent  = ent[i-1];
      assign p_vld  = vld[i-1];
      assign p_keep = keep[i-1];
    end
    glb_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl_i),
      .prev_entry_i (p_ent),
      .prev_valid_i (p_vld),
      .prev_keep_i  (p_keep),
      .next_entry_i (ent[i+1]),
      .next_valid_i (vld[i+1]),
      .entry_o      (ent[i]),
      .valid_o      (vld[i]),
      .keep_o       (keep[i])
    );
  end

  assign head_o         = ent[0];
  assign second_o       = ent[1];
  assign second_valid_o = vld[1];

endmodule

/* sim/glyph_layout_checker.sv */
`timescale 1ns / 1ps

module glyph_layout_checker
  import glb_pkg::*;
#(
  parameter int unsigned MaxChars = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                start_i,
  input  logic                busy_i,
  input  logic [CodeW-1:0]    char_code_i,
  input  logic [GlyphW-1:0]   glyph_index_i,
  input  logic [AdvW-1:0]     advance_i,
  input  logic [BearW-1:0]    left_bearing_i,
  input  logic                last_char_i,
  input  logic                result_valid_i,
  input  logic [GlyphW-1:0]   out_glyph_i,
  input  logic [XW-1:0]       x_pos_i,
  input  logic [YW-1:0]       y_pos_i,
  input  logic                run_end_i,
  input  logic [RunW-1:0]     run_length_i,
  input  logic                last_out_i,
  output int                  mismatch_count_o,
  output int                  checked_count_o,
  output int                  pending_o
);

  localparam int unsigned CntW = 7;
  localparam int unsigned IdxW = $clog2(MaxChars);
  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    logic [GlyphW-1:0] glyph;
    logic [XW-1:0]     x;
    logic [YW-1:0]     y;
    logic              run_end;
    logic [RunW-1:0]   run_len;
    logic              last;
  } placed_glyph_t;

  placed_glyph_t   expected_glyphs[$];
  entry_t          text_store[MaxChars];
  logic [PenW-1:0] pen_x;
  logic [ColW-1:0] column;
  logic [LineW-1:0] line_no;
  logic [CntW-1:0] stored;
  logic [CntW-1:0] taken;
  logic [ColW-1:0] wrap_col;
  logic [StepW-1:0] line_step;

  task automatic clear_text();
    pen_x   = '0;
    column  = '0;
    line_no = '0;
    stored  = '0;
    taken   = '0;
  endtask

  // Places one character and, at the end of a text, queues the sorted burst or the empty marker.
  task automatic layout_char(input logic [CodeW-1:0] code, input logic [GlyphW-1:0] glyph,
                             input logic [AdvW-1:0] adv, input logic [BearW-1:0] bear,
                             input logic last);
    entry_t           held;
    placed_glyph_t    res;
    int               count;
    int               n;
    int               j;
    logic             end_run;
    logic [RunW-1:0]  run;
    logic [ProdW-1:0] prod;
    if (taken < MaxChars) begin
      taken = taken + 1'b1;
      if (code == NewlineCode) begin
        column  = '0;
        pen_x   = '0;
        line_no = line_no + 1'b1;
      end else begin
        held.glyph = glyph;
        held.x     = {1'b0, pen_x} - {{(XW-BearW){bear[BearW-1]}}, bear};
        held.line  = line_no;
        text_store[stored[IdxW-1:0]] = held;
        stored = stored + 1'b1;
        if (column == wrap_col) begin
          column  = '0;
          pen_x   = '0;
          line_no = line_no + 1'b1;
        end else begin
          pen_x  = pen_x + PenW'(adv);
          column = column + 1'b1;
        end
      end
    end
    if (last) begin
      count = int'(stored);
      if (count == 0) begin
        res      = '0;
        res.last = 1'b1;
        expected_glyphs.push_back(res);
      end else begin
        // Insertion sort keeps equal glyphs in arrival order.
        for (n = 1; n < count; n++) begin
          held = text_store[n];
          j = n;
          while (j > 0 && text_store[j-1].glyph < held.glyph) begin
            text_store[j] = text_store[j-1];
            j--;
          end
          text_store[j] = held;
        end
        run = '0;
        for (n = 0; n < count; n++) begin
          if (n + 1 == count) begin
            end_run = 1'b1;
          end else begin
            end_run = text_store[n+1].glyph != text_store[n].glyph;
          end
          run = run + 1'b1;
          prod = ProdW'(text_store[n].line) * ProdW'(line_step);
          res.glyph   = text_store[n].glyph;
          res.x       = text_store[n].x;
          res.y       = YW'(prod >> FracBits);
          res.run_end = end_run;
          res.run_len = end_run ? run : '0;
          res.last    = (n + 1 == count);
          expected_glyphs.push_back(res);
          if (end_run) begin
            run = '0;
          end
        end
      end
      clear_text();
    end
  endtask

  task automatic check_result();
    placed_glyph_t seen;
    placed_glyph_t want;
    seen = '{out_glyph_i, x_pos_i, y_pos_i, run_end_i, run_length_i, last_out_i};
    if (expected_glyphs.size() == 0) begin
      mismatch_count_o++;
      if (mismatch_count_o <= ReportLimit) begin
        $display("%0t: unexpected result glyph=%0d x=%0d y=%0d end=%0b len=%0d last=%0b",
                 $time, seen.glyph, $signed(seen.x), seen.y, seen.run_end, seen.run_len,
                 seen.last);
      end
    end else begin
      want = expected_glyphs.pop_front();
      checked_count_o++;
      if (seen !== want) begin
        mismatch_count_o++;
        if (mismatch_count_o <= ReportLimit) begin
          $display("%0t: expected glyph=%0d x=%0d y=%0d end=%0b len=%0d last=%0b",
                   $time, want.glyph, $signed(want.x), want.y, want.run_end, want.run_len,
                   want.last);
          $display("%0t:      got glyph=%0d x=%0d y=%0d end=%0b len=%0d last=%0b",
                   $time, seen.glyph, $signed(seen.x), seen.y, seen.run_end, seen.run_len,
                   seen.last);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_text();
      wrap_col  = WrapColReset;
      line_step = '0;
      expected_glyphs.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgWrapColumn: wrap_col = cfg_wdata_i[ColW-1:0];
          CfgLineStep:   line_step = cfg_wdata_i[StepW-1:0];
          default: ;
        endcase
      end
      if (result_valid_i) begin
        check_result();
      end
      if (start_i && !busy_i) begin
        layout_char(char_code_i, glyph_index_i, advance_i, left_bearing_i, last_char_i);
      end
      pending_o = expected_glyphs.size();
    end
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
  import glb_pkg::*;

  localparam int unsigned MaxChars = 64;
  // Watchdog limit, with a wide margin over the longest run.
  localparam int unsigned CycleLimit = 200000;
  // Pause after the last expected result before touching the registers.
  localparam int unsigned SettleCycles = 4;
  // A full burst holds at most MaxChars results, so this covers any straggler.
  localparam int unsigned DrainCycles = MaxChars + 16;
  localparam int unsigned RandomItems = 300;
  localparam int unsigned Phases = 3;

  // Register indexes past the list; the block must ignore writes to them.
  localparam logic [CfgIdxW-1:0] CfgSpareLo = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgSpareHi = CfgIdxW'(3);
  localparam logic [ColW-1:0]    WrapMax    = '1;
  localparam logic [StepW-1:0]   StepMax    = '1;

  logic                clk;
  logic                rst_n         = 1'b0;
  logic                cfg_we        = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx       = '0;
  logic [CfgDataW-1:0] cfg_wdata     = '0;
  logic                start         = 1'b0;
  logic                busy;
  logic [CodeW-1:0]    char_code     = '0;
  logic [GlyphW-1:0]   glyph_index   = '0;
  logic [AdvW-1:0]     advance       = '0;
  logic [BearW-1:0]    left_bearing  = '0;
  logic                last_char     = 1'b0;
  logic                result_valid;
  logic [GlyphW-1:0]   out_glyph;
  logic [XW-1:0]       x_pos;
  logic [YW-1:0]       y_pos;
  logic                run_end;
  logic [RunW-1:0]     run_length;
  logic                last_out;

  int mismatches;
  int results_checked;
  int pending;
  int idle_pct;
  int items_sent;
  int texts_sent;
  int configs_done;

  glyph_layout_batcher_core #(
    .MAX_CHARS(MaxChars)
  ) DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .start_i        (start),
    .busy_o         (busy),
    .char_code_i    (char_code),
    .glyph_index_i  (glyph_index),
    .advance_i      (advance),
    .left_bearing_i (left_bearing),
    .last_char_i    (last_char),
    .result_valid_o (result_valid),
    .out_glyph_o    (out_glyph),
    .x_pos_o        (x_pos),
    .y_pos_o        (y_pos),
    .run_end_o      (run_end),
    .run_length_o   (run_length),
    .last_out_o     (last_out)
  );

  // The checker sees the same pins as the block, keeps its own copy of the
  // layout state and compares every burst entry against its prediction.
  glyph_layout_checker #(
    .MaxChars(MaxChars)
  ) u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .start_i          (start),
    .busy_i           (busy),
    .char_code_i      (char_code),
    .glyph_index_i    (glyph_index),
    .advance_i        (advance),
    .left_bearing_i   (left_bearing),
    .last_char_i      (last_char),
    .result_valid_i   (result_valid),
    .out_glyph_i      (out_glyph),
    .x_pos_i          (x_pos),
    .y_pos_i          (y_pos),
    .run_end_i        (run_end),
    .run_length_i     (run_length),
    .last_out_i       (last_out),
    .mismatch_count_o (mismatches),
    .checked_count_o  (results_checked),
    .pending_o        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a missing burst ends the run here.
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("Run stopped after %0d cycles with %0d results still expected.",
             CycleLimit, pending);
    $display("Test completed with failures");
    $finish;
  end

  // Issues one character request. The sender may idle first; the request is
  // taken at the first rising edge where busy is low. Busy is looked at on
  // the falling edge so the decision never races the block's own update.
  task automatic send_char(input logic [CodeW-1:0] code, input logic [GlyphW-1:0] glyph,
                           input logic [AdvW-1:0] adv, input logic [BearW-1:0] bear,
                           input logic last);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    char_code    <= code;
    glyph_index  <= glyph;
    advance      <= adv;
    left_bearing <= bear;
    last_char    <= last;
    do @(negedge clk); while (busy);
    @(posedge clk);
    items_sent++;
    if (last) begin
      texts_sent++;
    end
  endtask

  // Drops start and waits until every predicted result has come out, plus a
  // short settle, so that the registers may be written safely.
  task automatic go_quiet();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Writes both registers on back-to-back cycles, then hits one of the spare
  // indexes with junk. Upper data bits above the wrap column are noise too.
  task automatic configure(input logic [ColW-1:0] wrap, input logic [StepW-1:0] step);
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgWrapColumn;
    cfg_wdata <= {(CfgDataW-ColW)'($urandom), wrap};
    @(posedge clk);
    cfg_idx   <= CfgLineStep;
    cfg_wdata <= CfgDataW'(step);
    @(posedge clk);
    cfg_idx   <= $urandom_range(1) ? CfgSpareHi : CfgSpareLo;
    cfg_wdata <= CfgDataW'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    configs_done++;
  endtask

  // Picks a setting, leaning toward the corners: a wrap column of zero wraps
  // after every character, small columns wrap often, all ones almost never.
  task automatic random_config();
    logic [ColW-1:0]  wrap;
    logic [StepW-1:0] step;
    case ($urandom_range(4))
      0: wrap = '0;
      1: wrap = WrapMax;
      2: wrap = ColW'($urandom_range(1, 4));
      3: wrap = ColW'($urandom);
      default: wrap = ColW'($urandom_range(5, 12));
    endcase
    case ($urandom_range(3))
      0: step = '0;
      1: step = StepMax;
      default: step = StepW'($urandom);
    endcase
    configure(wrap, step);
  endtask

  // Sends one text of len characters, the final one marked last. Newlines
  // are mixed in, and glyphs often come from a tiny set so that runs of
  // equal glyphs form and the stable ordering of ties is exercised.
  task automatic send_text(input int len);
    int                i;
    logic [CodeW-1:0]  code;
    logic [GlyphW-1:0] glyph;
    logic [AdvW-1:0]   adv;
    for (i = 0; i < len; i++) begin
      code  = ($urandom_range(99) < 15) ? NewlineCode : CodeW'($urandom);
      glyph = $urandom_range(2) != 0 ? GlyphW'($urandom_range(5)) : GlyphW'($urandom);
      adv   = $urandom_range(1) != 0 ? AdvW'($urandom_range(40)) : AdvW'($urandom);
      send_char(code, glyph, adv, BearW'($urandom), i == len - 1);
    end
  endtask

  initial begin
    int phase;
    int phase_items;
    int len;
    idle_pct     = 23;
    items_sent   = 0;
    texts_sent   = 0;
    configs_done = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed texts. The first runs on the reset register values: no wrap
    // in sight and a line step of zero. It mixes the extreme advance and
    // bearings, the top code point, glyphs 0 and all ones, a newline, and
    // three characters of glyph 5 whose order must survive the sort.
    send_char(CodeW'(65), GlyphW'(5), AdvW'(16'hFFFF), BearW'(16'h8000), 1'b0);
    send_char(NewlineCode, GlyphW'(9), AdvW'(3), BearW'(0), 1'b0);
    send_char(CodeW'(21'h1FFFFF), GlyphW'(16'hFFFF), AdvW'(100), BearW'(16'h7FFF), 1'b0);
    send_char(CodeW'(0), GlyphW'(5), AdvW'(0), BearW'(16'hFFFF), 1'b0);
    send_char(CodeW'(66), GlyphW'(0), AdvW'(7), BearW'(0), 1'b0);
    send_char(CodeW'(67), GlyphW'(5), AdvW'(1), BearW'(2), 1'b1);
    // A text of nothing but a newline yields only the empty marker.
    send_char(NewlineCode, GlyphW'(16'hFFFF), AdvW'(16'hFFFF), BearW'(16'hFFFF), 1'b1);
    go_quiet();

    // Wrap column zero: every character breaks the line right after itself,
    // and the largest line step pushes y to its widest values.
    configure('0, StepMax);
    send_char(CodeW'(97), GlyphW'(7), AdvW'(10), BearW'(1), 1'b0);
    send_char(CodeW'(98), GlyphW'(3), AdvW'(20), BearW'(16'hFFF0), 1'b0);
    send_char(CodeW'(99), GlyphW'(7), AdvW'(30), BearW'(0), 1'b0);
    send_char(CodeW'(100), GlyphW'(3), AdvW'(40), BearW'(5), 1'b1);
    go_quiet();

    // Wrap after the third character of a line, with a step of one and a
    // half lines so that the ten fraction bits are truncated on odd lines.
    configure(ColW'(2), StepW'(1536));
    send_char(CodeW'(104), GlyphW'(12), AdvW'(8), BearW'(0), 1'b0);
    send_char(CodeW'(105), GlyphW'(4), AdvW'(9), BearW'(1), 1'b0);
    send_char(CodeW'(106), GlyphW'(12), AdvW'(10), BearW'(2), 1'b0);
    send_char(CodeW'(107), GlyphW'(4), AdvW'(11), BearW'(3), 1'b0);
    send_char(NewlineCode, GlyphW'(0), AdvW'(0), BearW'(0), 1'b0);
    send_char(CodeW'(108), GlyphW'(12), AdvW'(12), BearW'(16'hFFFC), 1'b0);
    send_char(CodeW'(109), GlyphW'(20), AdvW'(13), BearW'(0), 1'b0);
    send_char(CodeW'(110), GlyphW'(4), AdvW'(14), BearW'(0), 1'b1);
    // A single visible character that is also the last one.
    send_char(CodeW'(111), GlyphW'(1), AdvW'(1), BearW'(0), 1'b1);
    go_quiet();

    // Random texts in three idling regimes: the sender idles often, then
    // very often, then never. Most texts are short; about one in twelve is long,
    // near the store capacity and often past it, so that the tail of it is ignored
    // while its last mark still closes the text.
    for (phase = 0; phase < Phases; phase++) begin
      case (phase)
        0: idle_pct = 23;
        1: idle_pct = 47;
        default: idle_pct = 0;
      endcase
      random_config();
      phase_items = 0;
      while (phase_items < RandomItems / Phases) begin
        if (phase_items > 0 && $urandom_range(3) == 0) begin
          go_quiet();
          random_config();
        end
        len = ($urandom_range(11) == 0) ? $urandom_range(MaxChars - 4, MaxChars + 6)
                                        : $urandom_range(1, 12);
        send_text(len);
        phase_items += (len > MaxChars) ? MaxChars : len;
      end
      go_quiet();
    end

    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
    $display("Covered %0d character requests in %0d texts over %0d register settings.",
             items_sent, texts_sent, configs_done);
    $display("Checked %0d placed glyphs, %0d mismatches, %0d still expected.",
             results_checked, mismatches, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/glb_pkg.sv
rtl/glb_cell.sv
rtl/glb_chain.sv
rtl/glyph_layout_batcher_core.sv
sim/glyph_layout_checker.sv
sim/tb.sv
